// File: rtl/ffih_pkg.sv
// Package for the first-fit implicit-list heap manager.
// Holds the item structs, operation, status and register codes, and the state type.
// Depends on nothing; every other file imports it.
package ffih_pkg;

    localparam int HDR_W     = 18;
    localparam int HDR_BYTES = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [HDR_W-1:0] STATE_BITS = 18'h7;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] block_address;
        logic [16:0] request_bytes;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_address;
        logic [1:0]  status;
        logic        must_copy;
        logic [31:0] copy_source;
        logic [16:0] copy_bytes;
    } t_out_item;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOCATE,
        S_FIT,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

// File: rtl/ffih_hdr_ram.sv
// Header store of the heap manager: one write port and one read port.
// The read data is registered, so it appears in the cycle after the address.
// Depends on ffih_pkg for the header width.
module ffih_hdr_ram #(
    parameter int DEPTH = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [ffih_pkg::HDR_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [ffih_pkg::HDR_W-1:0] o_rdata
);
    import ffih_pkg::*;

    logic [HDR_W-1:0] r_mem [DEPTH];
    logic [HDR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/first_fit_implicit_heap.sv
// First-fit heap manager over an implicit list of 8-byte block headers.
// An item walks the headers through the single read port and then writes at most 3 headers;
// a realloc that moves walks the list twice.
// One item is in work at a time; the output register lets the next item in while a result waits.
// After reset the S_INIT state writes the first header; writing the base or length register does the same.
// Depends on ffih_pkg and ffih_hdr_ram.
module first_fit_implicit_heap #(
    parameter int HEAP_BYTES  = 65536,
    parameter int ALIGN_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffih_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ffih_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ffih_pkg::t_out_item            o_out_item
);
    import ffih_pkg::*;

    localparam int DEPTH = HEAP_BYTES / HDR_BYTES;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OFF_W = $clog2(HEAP_BYTES + 1);

    function automatic logic [OFF_W-1:0] eff_bytes(input logic [16:0] size);
        logic [31:0] s;
        s = {15'd0, size};
        if (s > 32'(HEAP_BYTES)) begin
            s = 32'(HEAP_BYTES);
        end
        s = s & ~32'(ALIGN_BYTES - 1) & ~{14'd0, STATE_BITS};
        return s[OFF_W-1:0];
    endfunction

    t_state           r_state, n_state;
    logic [31:0]      r_heap_base;
    logic [16:0]      r_heap_len;
    logic [16:0]      r_max_request;
    logic [1:0]       r_op, n_op;
    logic [31:0]      r_addr, n_addr;
    logic [31:0]      r_rel, n_rel;
    logic [17:0]      r_n, n_n;
    logic [OFF_W-1:0] r_cur, n_cur;
    logic             r_moving, n_moving;
    logic [HDR_W-1:0] r_old_size, n_old_size;
    logic [2:0]       r_wv, n_wv;
    logic [IDX_W-1:0] r_wa [3];
    logic [IDX_W-1:0] n_wa [3];
    logic [HDR_W-1:0] r_wd [3];
    logic [HDR_W-1:0] n_wd [3];
    t_out_item        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [HDR_W-1:0] w_rdata;
    logic [OFF_W-1:0] w_eff;
    logic             w_heap_ok;
    logic [16:0]      w_init_size;
    logic [OFF_W-1:0] w_init_eff;
    logic             w_init_we;
    logic [HDR_W-1:0] w_init_data;
    logic [17:0]      w_req_n;
    logic             w_fit_ok;
    logic [HDR_W-1:0] w_sz;
    logic             w_free;
    logic             w_at_end;
    logic [31:0]      w_next32;
    logic [OFF_W-1:0] w_next_cur;
    logic [IDX_W-1:0] w_cur_idx;
    logic [31:0]      w_split32;
    logic [IDX_W-1:0] w_split_idx;
    logic [HDR_W-1:0] w_excess;
    logic             w_tight;
    logic [HDR_W-1:0] w_split_data;
    logic [31:0]      w_cur_payload;
    logic             w_free_like;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [HDR_W-1:0] w_wdata;
    logic             w_slot_we;
    logic [IDX_W-1:0] w_slot_addr;
    logic [HDR_W-1:0] w_slot_data;

    ffih_hdr_ram #(
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_cur[IDX_W+2:3]),
        .o_rdata (w_rdata)
    );

    assign w_eff       = eff_bytes(r_heap_len);
    assign w_heap_ok   = w_eff > OFF_W'(HDR_BYTES);
    assign w_init_size = (i_cfg_we && i_cfg_index == CFG_HEAP_SIZE) ? i_cfg_data[16:0]
                                                                    : r_heap_len;
    assign w_init_eff  = eff_bytes(w_init_size);
    assign w_init_we   = (r_state == S_INIT) ||
                         (i_cfg_we && (i_cfg_index == CFG_HEAP_BASE ||
                                       i_cfg_index == CFG_HEAP_SIZE));
    assign w_init_data = HDR_W'(w_init_eff - OFF_W'(HDR_BYTES)) | HDR_W'(1);

    assign w_req_n  = ({1'b0, i_in_item.request_bytes} + 18'(ALIGN_BYTES - 1)) &
                      ~18'(ALIGN_BYTES - 1);
    assign w_fit_ok = w_heap_ok && (w_req_n != 18'd0) && (w_req_n <= {1'b0, r_max_request});

    assign w_sz          = w_rdata & ~STATE_BITS;
    assign w_free        = w_rdata[0];
    assign w_at_end      = r_cur >= w_eff;
    assign w_next32      = 32'(r_cur) + 32'(HDR_BYTES) + 32'(w_sz);
    assign w_next_cur    = w_next32[OFF_W-1:0];
    assign w_cur_idx     = r_cur[IDX_W+2:3];
    assign w_split32     = 32'(r_cur) + 32'(HDR_BYTES) + 32'(r_n);
    assign w_split_idx   = w_split32[IDX_W+2:3];
    assign w_excess      = w_sz - HDR_W'(r_n);
    assign w_tight       = w_excess <= HDR_W'(HDR_BYTES);
    assign w_split_data  = (w_excess - HDR_W'(HDR_BYTES)) | HDR_W'(1);
    assign w_cur_payload = r_heap_base + 32'(r_cur) + 32'(HDR_BYTES);
    assign w_free_like   = (r_op == OP_FREE) || (r_n == 18'd0);

    always_comb begin
        w_slot_we   = 1'b0;
        w_slot_addr = r_wa[0];
        w_slot_data = r_wd[0];
        if (r_state == S_WRITE) begin
            if (r_wv[0]) begin
                w_slot_we = 1'b1;
            end else if (r_wv[1]) begin
                w_slot_we   = 1'b1;
                w_slot_addr = r_wa[1];
                w_slot_data = r_wd[1];
            end else if (r_wv[2]) begin
                w_slot_we   = 1'b1;
                w_slot_addr = r_wa[2];
                w_slot_data = r_wd[2];
            end
        end
    end

    assign w_we    = w_init_we || w_slot_we;
    assign w_waddr = w_init_we ? '0 : w_slot_addr;
    assign w_wdata = w_init_we ? w_init_data : w_slot_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= 32'd0;
            r_heap_len    <= 17'h10000;
            r_max_request <= 17'h10000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEAP_BASE:   r_heap_base   <= i_cfg_data;
                CFG_HEAP_SIZE:   r_heap_len    <= i_cfg_data[16:0];
                CFG_MAX_REQUEST: r_max_request <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
            r_wv        <= 3'b000;
            r_moving    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wv        <= n_wv;
            r_moving    <= n_moving;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_addr     <= n_addr;
        r_rel      <= n_rel;
        r_n        <= n_n;
        r_cur      <= n_cur;
        r_old_size <= n_old_size;
        r_wa       <= n_wa;
        r_wd       <= n_wd;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_addr      = r_addr;
        n_rel       = r_rel;
        n_n         = r_n;
        n_cur       = '0;
        n_moving    = r_moving;
        n_old_size  = r_old_size;
        n_wv        = r_wv;
        n_wa        = r_wa;
        n_wd        = r_wd;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_INIT: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = i_in_item.op;
                    n_addr       = i_in_item.block_address;
                    n_rel        = i_in_item.block_address - r_heap_base - 32'(HDR_BYTES);
                    n_n          = w_req_n;
                    n_res        = '0;
                    n_res.status = ST_REFUSED;
                    n_wv         = 3'b000;
                    n_moving     = 1'b0;
                    n_state      = S_DONE;
                    case (i_in_item.op)
                        OP_ALLOC: begin
                            if (w_fit_ok) begin
                                n_state = S_FIT;
                            end
                        end
                        OP_FREE: begin
                            n_res.status = ST_NONE;
                            if (i_in_item.block_address != 32'd0 && w_heap_ok) begin
                                n_state = S_LOCATE;
                            end
                        end
                        OP_REALLOC: begin
                            if (i_in_item.block_address == 32'd0) begin
                                if (w_fit_ok) begin
                                    n_state = S_FIT;
                                end
                            end else begin
                                if (w_req_n == 18'd0) begin
                                    n_res.status = ST_NONE;
                                end
                                if (w_heap_ok) begin
                                    n_state = S_LOCATE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOCATE: begin
                if (w_at_end) begin
                    n_state = S_DONE;
                end else if (32'(r_cur) == r_rel) begin
                    if (w_free_like) begin
                        n_wv[2] = 1'b1;
                        n_wa[2] = w_cur_idx;
                        n_wd[2] = w_rdata | HDR_W'(1);
                        n_state = S_WRITE;
                    end else if (w_free) begin
                        n_state = S_DONE;
                    end else if (w_sz >= HDR_W'(r_n)) begin
                        n_res.result_address = r_addr;
                        n_res.status         = ST_OK;
                        if (!w_tight) begin
                            n_wv[0] = 1'b1;
                            n_wa[0] = w_split_idx;
                            n_wd[0] = w_split_data;
                            n_wv[1] = 1'b1;
                            n_wa[1] = w_cur_idx;
                            n_wd[1] = HDR_W'(r_n);
                        end
                        n_state = S_WRITE;
                    end else if (r_n <= {1'b0, r_max_request}) begin
                        n_moving   = 1'b1;
                        n_old_size = w_sz;
                        n_wa[2]    = w_cur_idx;
                        n_wd[2]    = w_rdata | HDR_W'(1);
                        n_state    = S_FIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_cur = w_next_cur;
                end
            end
            S_FIT: begin
                if (w_at_end) begin
                    n_state = S_DONE;
                end else if (w_free && w_sz >= HDR_W'(r_n)) begin
                    n_res.result_address = w_cur_payload;
                    n_res.status         = ST_OK;
                    n_wv[1] = 1'b1;
                    n_wa[1] = w_cur_idx;
                    if (w_tight) begin
                        n_wd[1] = w_sz;
                    end else begin
                        n_wd[1] = HDR_W'(r_n);
                        n_wv[0] = 1'b1;
                        n_wa[0] = w_split_idx;
                        n_wd[0] = w_split_data;
                    end
                    if (r_moving) begin
                        n_wv[2]           = 1'b1;
                        n_res.must_copy   = 1'b1;
                        n_res.copy_source = r_addr;
                        n_res.copy_bytes  = r_old_size[16:0];
                    end
                    n_state = S_WRITE;
                end else begin
                    n_cur = w_next_cur;
                end
            end
            S_WRITE: begin
                if (r_wv[0]) begin
                    n_wv[0] = 1'b0;
                end else if (r_wv[1]) begin
                    n_wv[1] = 1'b0;
                end else if (r_wv[2]) begin
                    n_wv[2] = 1'b0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_cur_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOCATE || r_state == S_FIT) |-> r_cur[2:0] == 3'd0)
        else $error("Header walk offset is not on a header boundary.");

    a_walk_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOCATE || r_state == S_FIT) && n_state == r_state)
        |=> r_cur > $past(r_cur))
        else $error("Header walk did not move forward.");

    a_writes_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_wv == 3'b000)
        else $error("Header writes left pending when a new item may enter.");

    a_copy_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.must_copy) |->
        (o_out_item.status == ST_OK && o_out_item.copy_bytes != 17'd0))
        else $error("Copy request on an item that did not succeed.");

endmodule
